>>> design/eql_pkg.sv
`default_nettype none
package eql_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 512;
    localparam int DIR_BITS    = 16;
    localparam int ANGLE_STEPS = 16;

    localparam int IDX_W       = 19;
    localparam int STORE_DEPTH = 1 << IDX_W;
    localparam int RGB_W       = 24;
    localparam int W_REG_W     = 11;
    localparam int H_REG_W     = 10;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 9;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 2;

    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

    localparam int SQ_W        = 2 * DIR_BITS;
    localparam int SQRT_STEPS  = DIR_BITS;
    localparam int REM_W       = DIR_BITS + 4;
    localparam int VEC_SHIFT   = 16;
    localparam int VEC_W       = 36;
    localparam int ANG_W       = 34;
    localparam int TURN_BITS   = 32;
    localparam int THETA_W     = TURN_BITS + 1;
    localparam int CPROD_W     = TURN_BITS + W_REG_W;
    localparam int RPROD_W     = THETA_W + H_REG_W;
    localparam int RFULL_W     = RPROD_W - (TURN_BITS - 1);
    localparam int ADDR_SUM_W  = ROW_W + W_REG_W + 1;

    localparam int STAGE_M1    = 2 + SQRT_STEPS + ANGLE_STEPS + 1;
    localparam int STAGE_MEM   = STAGE_M1 + 2;
    localparam int LAT         = STAGE_MEM + 2;

    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * DIR_BITS - 2);
    localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(64'd2147483648);

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_LOOKUP,
        KIND_BLACK
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_LOADED = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [W_REG_W-1:0] width;
        logic [H_REG_W-1:0] height;
    } t_geom;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        logic [RGB_W-1:0]  rgb;
    } t_meta;

    typedef struct packed {
        t_meta                       meta;
        logic signed [DIR_BITS-1:0]  x;
        logic signed [DIR_BITS-1:0]  y;
        logic signed [DIR_BITS-1:0]  z;
    } t_item;

    function automatic logic [TURN_BITS-1:0] atan_turn(input logic [4:0] i);
        case (i)
            5'd0:  atan_turn = 32'd536870912;
            5'd1:  atan_turn = 32'd316933406;
            5'd2:  atan_turn = 32'd167458907;
            5'd3:  atan_turn = 32'd85004756;
            5'd4:  atan_turn = 32'd42667331;
            5'd5:  atan_turn = 32'd21354465;
            5'd6:  atan_turn = 32'd10679838;
            5'd7:  atan_turn = 32'd5340245;
            5'd8:  atan_turn = 32'd2670163;
            5'd9:  atan_turn = 32'd1335087;
            5'd10: atan_turn = 32'd667544;
            5'd11: atan_turn = 32'd333772;
            5'd12: atan_turn = 32'd166886;
            5'd13: atan_turn = 32'd83443;
            5'd14: atan_turn = 32'd41722;
            5'd15: atan_turn = 32'd20861;
            5'd16: atan_turn = 32'd10430;
            5'd17: atan_turn = 32'd5215;
            5'd18: atan_turn = 32'd2608;
            5'd19: atan_turn = 32'd1304;
            5'd20: atan_turn = 32'd652;
            5'd21: atan_turn = 32'd326;
            5'd22: atan_turn = 32'd163;
            5'd23: atan_turn = 32'd81;
            5'd24: atan_turn = 32'd41;
            5'd25: atan_turn = 32'd20;
            5'd26: atan_turn = 32'd10;
            5'd27: atan_turn = 32'd5;
            5'd28: atan_turn = 32'd3;
            5'd29: atan_turn = 32'd1;
            5'd30: atan_turn = 32'd1;
            default: atan_turn = 32'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> design/eql_ram.sv
`default_nettype none
module eql_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= mem[i_addr];
            end
        end
    end

endmodule
`default_nettype wire

>>> design/eql_front.sv
`default_nettype none
module eql_front import eql_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_command,
    input  logic [IDX_W-1:0]            i_texel_index,
    input  logic [7:0]                  i_texel_red,
    input  logic [7:0]                  i_texel_green,
    input  logic [7:0]                  i_texel_blue,
    input  logic signed [DIR_BITS-1:0]  i_dir_x,
    input  logic signed [DIR_BITS-1:0]  i_dir_y,
    input  logic signed [DIR_BITS-1:0]  i_dir_z,
    input  logic                        i_take,
    output logic                        o_valid,
    output t_item                       o_item,
    output t_geom                       o_geom
);

    logic [W_REG_W-1:0] r_width;
    logic [H_REG_W-1:0] r_height;
    logic               r_loaded;

    t_item              r_q [0:QUEUE_DEPTH-1];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QPTR_W:0]    r_cnt;

    t_item n_item;
    logic  accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= W_REG_W'(1);
            r_height <= H_REG_W'(1);
            r_loaded <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data[H_REG_W-1:0];
                CFG_LOADED: r_loaded <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            o_geom.width = W_REG_W'(1);
        end else if (r_width > W_REG_W'(MAX_WIDTH)) begin
            o_geom.width = W_REG_W'(MAX_WIDTH);
        end else begin
            o_geom.width = r_width;
        end
        if (r_height == '0) begin
            o_geom.height = H_REG_W'(1);
        end else if (r_height > H_REG_W'(MAX_HEIGHT)) begin
            o_geom.height = H_REG_W'(MAX_HEIGHT);
        end else begin
            o_geom.height = r_height;
        end
    end

    always_comb begin
        if (!i_command) begin
            n_item.meta.kind = KIND_WRITE;
        end else if (r_loaded) begin
            n_item.meta.kind = KIND_LOOKUP;
        end else begin
            n_item.meta.kind = KIND_BLACK;
        end
        n_item.meta.idx = i_texel_index;
        n_item.meta.rgb = {i_texel_red, i_texel_green, i_texel_blue};
        n_item.x        = i_dir_x;
        n_item.y        = i_dir_y;
        n_item.z        = i_dir_z;
    end

    assign full    = (r_cnt == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign accept  = push && !full;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_take) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({accept, i_take})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/eql_cordic.sv
`default_nettype none
module eql_cordic import eql_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [DIR_BITS:0]  i_num,
    input  logic signed [DIR_BITS:0]  i_den,
    output logic signed [ANG_W-1:0]   o_ang
);

    logic signed [VEC_W-1:0] r_x [0:ANGLE_STEPS];
    logic signed [VEC_W-1:0] r_z [0:ANGLE_STEPS];
    logic signed [ANG_W-1:0] r_a [0:ANGLE_STEPS];
    logic                    r_zero [0:ANGLE_STEPS];

    logic signed [VEC_W-1:0] n_x;
    logic signed [VEC_W-1:0] n_z;

    assign n_x = VEC_W'(i_num) <<< VEC_SHIFT;
    assign n_z = VEC_W'(i_den) <<< VEC_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_num == '0) && (i_den == '0);
            if (i_den < 0) begin
                r_x[0] <= -n_x;
                r_z[0] <= -n_z;
                r_a[0] <= HALF_TURN;
            end else begin
                r_x[0] <= n_x;
                r_z[0] <= n_z;
                r_a[0] <= '0;
            end
        end
    end

    for (genvar j = 0; j < ANGLE_STEPS; j++) begin : g_step
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] zs;
        logic signed [ANG_W-1:0] step;

        assign xs   = r_x[j] >>> j;
        assign zs   = r_z[j] >>> j;
        assign step = ANG_W'(atan_turn(5'(j)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[j+1] <= r_zero[j];
                if (r_x[j] > 0) begin
                    r_z[j+1] <= r_z[j] + xs;
                    r_x[j+1] <= r_x[j] - zs;
                    r_a[j+1] <= r_a[j] + step;
                end else begin
                    r_z[j+1] <= r_z[j] - xs;
                    r_x[j+1] <= r_x[j] + zs;
                    r_a[j+1] <= r_a[j] - step;
                end
            end
        end
    end

    assign o_ang = r_zero[ANGLE_STEPS] ? '0 : r_a[ANGLE_STEPS];

endmodule
`default_nettype wire

>>> design/eql_back.sv
`default_nettype none
module eql_back import eql_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_geom               i_geom,
    input  logic                i_valid,
    input  t_item               i_item,
    output logic                o_take,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [COL_W-1:0]    o_column,
    output logic [ROW_W-1:0]    o_row
);

    logic  en;
    logic  r_out_vld;
    logic  r_vld  [0:LAT-1];
    t_meta r_meta [0:LAT-1];

    logic signed [DIR_BITS-1:0] r_x0, r_y0, r_z0;
    logic signed [SQ_W-1:0]     ysq;

    logic [REM_W-1:0]           r_rem [0:SQRT_STEPS];
    logic [DIR_BITS-1:0]        r_q   [0:SQRT_STEPS];
    logic [SQ_W-1:0]            r_sv  [0:SQRT_STEPS];
    logic signed [DIR_BITS-1:0] r_sx  [0:SQRT_STEPS];
    logic signed [DIR_BITS-1:0] r_sy  [0:SQRT_STEPS];
    logic signed [DIR_BITS-1:0] r_sz  [0:SQRT_STEPS];

    logic signed [ANG_W-1:0] phi;
    logic signed [ANG_W-1:0] theta;
    logic [TURN_BITS-1:0]    u;
    logic [THETA_W-1:0]      tpos;
    logic [CPROD_W-1:0]      r_cprod;
    logic [RPROD_W-1:0]      r_rprod;
    logic [RFULL_W-1:0]      row_full;
    logic [H_REG_W-1:0]      hm1;
    logic [COL_W-1:0]        r_col2, r_col3, r_col4;
    logic [ROW_W-1:0]        r_row2, r_row3, r_row4;
    logic [ADDR_SUM_W-1:0]   addr_sum;
    logic [IDX_W-1:0]        r_addr;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_addr;
    logic [RGB_W-1:0]        mem_rdata;

    assign en     = !r_out_vld || pop;
    assign o_take = en && i_valid;
    assign empty  = !r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_meta[0] <= i_item.meta;
            for (int k = 1; k < LAT; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
            r_x0 <= i_item.x;
            r_y0 <= i_item.y;
            r_z0 <= i_item.z;
        end
    end

    assign ysq = r_y0 * r_y0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sv[0]  <= ONE_SQ - $unsigned(ysq);
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_sx[0]  <= r_x0;
            r_sy[0]  <= r_y0;
            r_sz[0]  <= r_z0;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam int D = SQRT_STEPS - 1 - j;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        logic             ge;

        assign sh    = {r_rem[j][REM_W-3:0], r_sv[j][2*D+1 -: 2]};
        assign trial = REM_W'({r_q[j], 2'b01});
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[j+1] <= ge ? sh - trial : sh;
                r_q[j+1]   <= {r_q[j][DIR_BITS-2:0], ge};
                r_sv[j+1]  <= r_sv[j];
                r_sx[j+1]  <= r_sx[j];
                r_sy[j+1]  <= r_sy[j];
                r_sz[j+1]  <= r_sz[j];
            end
        end
    end

    eql_cordic u_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ((DIR_BITS + 1)'(r_sx[SQRT_STEPS])),
        .i_den ((DIR_BITS + 1)'(r_sz[SQRT_STEPS])),
        .o_ang (phi)
    );

    eql_cordic u_theta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ($signed({1'b0, r_q[SQRT_STEPS]})),
        .i_den ((DIR_BITS + 1)'(r_sy[SQRT_STEPS])),
        .o_ang (theta)
    );

    assign u    = phi[TURN_BITS-1:0] + {1'b1, {(TURN_BITS - 1){1'b0}}};
    assign tpos = theta[ANG_W-1] ? '0 : theta[THETA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cprod <= CPROD_W'(u) * CPROD_W'(i_geom.width);
            r_rprod <= RPROD_W'(tpos) * RPROD_W'(i_geom.height);
        end
    end

    assign row_full = r_rprod[RPROD_W-1:TURN_BITS-1];
    assign hm1      = i_geom.height - 1'b1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col2 <= r_cprod[TURN_BITS +: COL_W];
            r_row2 <= (RFULL_W'(hm1) < row_full) ? ROW_W'(hm1) : ROW_W'(row_full);
        end
    end

    assign addr_sum = ADDR_SUM_W'(r_row2) * ADDR_SUM_W'(i_geom.width)
                    + ADDR_SUM_W'(r_col2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_addr <= addr_sum[IDX_W-1:0];
            r_col3 <= r_col2;
            r_row3 <= r_row2;
            r_col4 <= r_col3;
            r_row4 <= r_row3;
        end
    end

    assign mem_we   = r_vld[STAGE_MEM] && (r_meta[STAGE_MEM].kind == KIND_WRITE);
    assign mem_addr = (r_meta[STAGE_MEM].kind == KIND_WRITE) ? r_meta[STAGE_MEM].idx
                                                             : r_addr;

    eql_ram #(
        .WIDTH (RGB_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (r_meta[STAGE_MEM].rgb),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[LAT-1] && (r_meta[LAT-1].kind != KIND_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_meta[LAT-1].kind == KIND_LOOKUP) begin
                {o_red, o_green, o_blue} <= mem_rdata;
                o_column <= r_col4;
                o_row    <= r_row4;
            end else begin
                {o_red, o_green, o_blue} <= '0;
                o_column <= '0;
                o_row    <= '0;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/equirect_environment_lookup.sv
// A lookup item reaches the result ports via the queue stage, a 16-step
// square root, a 17-stage CORDIC, mapping and the registered texel memory
// read; a write item is written to memory at the memory stage. Throughput:
// one item per cycle, fully pipelined, while no result is waiting for pop.
// Reset: configuration returns to width 1, height 1, no image; queues empty.
// The texel memory is not cleared by reset.
`default_nettype none
module equirect_environment_lookup import eql_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_command,
    input  logic [IDX_W-1:0]            i_texel_index,
    input  logic [7:0]                  i_texel_red,
    input  logic [7:0]                  i_texel_green,
    input  logic [7:0]                  i_texel_blue,
    input  logic signed [DIR_BITS-1:0]  i_dir_x,
    input  logic signed [DIR_BITS-1:0]  i_dir_y,
    input  logic signed [DIR_BITS-1:0]  i_dir_z,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  o_red,
    output logic [7:0]                  o_green,
    output logic [7:0]                  o_blue,
    output logic [COL_W-1:0]            o_column,
    output logic [ROW_W-1:0]            o_row
);

    logic  take;
    logic  front_valid;
    t_item front_item;
    t_geom geom;

    eql_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_texel_index (i_texel_index),
        .i_texel_red   (i_texel_red),
        .i_texel_green (i_texel_green),
        .i_texel_blue  (i_texel_blue),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_take        (take),
        .o_valid       (front_valid),
        .o_item        (front_item),
        .o_geom        (geom)
    );

    eql_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (geom),
        .i_valid  (front_valid),
        .i_item   (front_item),
        .o_take   (take),
        .pop      (pop),
        .empty    (empty),
        .o_red    (o_red),
        .o_green  (o_green),
        .o_blue   (o_blue),
        .o_column (o_column),
        .o_row    (o_row)
    );

endmodule
`default_nettype wire
